[rtl/fta_pkg.sv]
// Shared types, constants and codes of the fixed-timestep accumulator.
`default_nettype none
package fta_pkg;

  localparam int unsigned ACC_WIDTH   = 48;
  localparam int unsigned ALPHA_BITS  = 20;
  localparam int unsigned ALPHA_OUT_W = 20;
  localparam int unsigned TS_W        = 63;
  localparam int unsigned STEP_W      = 32;
  localparam int unsigned CNT16_W     = 16;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CNT_W       = $clog2(ACC_WIDTH);

  localparam logic [STEP_W-1:0]  STEP_DEFAULT    = 32'd16666666;
  localparam logic [CNT16_W-1:0] CATCHUP_RESET   = 16'd16;
  localparam logic [CNT16_W-1:0] CATCHUP_DEFAULT = 16'd1;

  typedef logic [TS_W-1:0]       ts_t;
  typedef logic [ACC_WIDTH-1:0]  acc_t;
  typedef logic [STEP_W-1:0]     step_t;
  typedef logic [CNT16_W-1:0]    cnt16_t;
  typedef logic [ALPHA_BITS-1:0] alpha_t;

  typedef enum logic [1:0] {
    CMD_FRAME   = 2'd0,
    CMD_CONSUME = 2'd1,
    CMD_RESET   = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_LENGTH = 2'd0,
    CFG_MAX_DELTA   = 2'd1,
    CFG_MAX_CATCHUP = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_DELTA,
    S_ACC,
    S_DIV,
    S_CAP,
    S_SUB,
    S_FCHK,
    S_FRAC,
    S_OUT
  } state_e;

  typedef struct packed {
    step_t  step;
    step_t  max_delta;
    cnt16_t catchup;
  } cfg_t;

  typedef struct packed {
    logic latch;
    logic simple;
    logic delta;
    logic acc;
    logic div;
    logic cap;
    logic sub;
    logic fchk;
    logic frac;
    logic out_ld;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       running;
    logic       rem_ge_step;
  } dp_stat_t;

  typedef struct packed {
    ts_t                    frame_time;
    step_t                  delta;
    cnt16_t                 steps;
    logic [ALPHA_OUT_W-1:0] alpha;
    logic                   taken;
    cnt16_t                 pending;
    ts_t                    sim_time;
  } result_t;

endpackage
`default_nettype wire

[rtl/fta_if.sv]
// Handshake channels of the accumulator: event input, result output, register writes.
`default_nettype none
interface fta_in_if;
  import fta_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  ts_t        timestamp_ns;
  modport source (output valid, output cmd, output timestamp_ns, input ready);
  modport sink   (input valid, input cmd, input timestamp_ns, output ready);
endinterface

interface fta_out_if;
  import fta_pkg::*;
  logic                   valid;
  logic                   ready;
  ts_t                    frame_time_ns;
  step_t                  frame_dt_ns;
  cnt16_t                 steps_granted;
  logic [ALPHA_OUT_W-1:0] alpha_q20;
  logic                   step_taken;
  cnt16_t                 pending_left;
  ts_t                    sim_clock_ns;
  modport source (output valid, output frame_time_ns, output frame_dt_ns, output steps_granted,
                  output alpha_q20, output step_taken, output pending_left,
                  output sim_clock_ns, input ready);
  modport sink   (input valid, input frame_time_ns, input frame_dt_ns, input steps_granted,
                  input alpha_q20, input step_taken, input pending_left,
                  input sim_clock_ns, output ready);
endinterface

interface fta_cfg_if;
  import fta_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[rtl/fta_cfg.sv]
// Configuration registers with zero-selects-default resolution.
`default_nettype none
module fta_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_valid_i,
  output logic                          wr_ready_o,
  input  logic [fta_pkg::CFG_IDX_W-1:0] wr_index_i,
  input  logic [fta_pkg::CFG_DATA_W-1:0] wr_data_i,
  output fta_pkg::cfg_t                 cfg_o
);
  import fta_pkg::*;

  step_t  step_q;
  step_t  max_delta_q;
  cnt16_t catchup_q;
  step_t  eff_step;

  assign wr_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= STEP_DEFAULT;
      max_delta_q <= '0;
      catchup_q   <= CATCHUP_RESET;
    end else if (wr_valid_i) begin
      case (wr_index_i)
        CFG_STEP_LENGTH: step_q      <= wr_data_i[STEP_W-1:0];
        CFG_MAX_DELTA:   max_delta_q <= wr_data_i[STEP_W-1:0];
        CFG_MAX_CATCHUP: catchup_q   <= wr_data_i[CNT16_W-1:0];
        default: ;
      endcase
    end
  end

  assign eff_step          = (step_q != '0) ? step_q : STEP_DEFAULT;
  assign cfg_o.step        = eff_step;
  assign cfg_o.max_delta   = (max_delta_q != '0) ? max_delta_q : eff_step;
  assign cfg_o.catchup     = (catchup_q != '0) ? catchup_q : CATCHUP_DEFAULT;

endmodule
`default_nettype wire

[rtl/fta_ctrl.sv]
// Sequencer for event decode, serial division, catch-up cap and fraction steps.
`default_nettype none
module fta_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  fta_pkg::dp_stat_t stat_i,
  output fta_pkg::dp_cmd_t  cmd_o
);
  import fta_pkg::*;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             slot_free;
  logic             frame_run;

  assign slot_free = !out_valid_q || out_ready_i;
  assign frame_run = (stat_i.cmd == CMD_FRAME) && stat_i.running;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      S_IDLE:   if (in_valid_i) state_d = S_DECODE;
      S_DECODE: state_d = frame_run ? S_DELTA : S_OUT;
      S_DELTA:  state_d = S_ACC;
      S_ACC: begin
        state_d = S_DIV;
        cnt_d   = CNT_W'(ACC_WIDTH - 1);
      end
      S_DIV: begin
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) state_d = S_CAP;
      end
      S_CAP:    state_d = S_SUB;
      S_SUB:    state_d = S_FCHK;
      S_FCHK: begin
        state_d = stat_i.rem_ge_step ? S_OUT : S_FRAC;
        cnt_d   = CNT_W'(ALPHA_BITS - 1);
      end
      S_FRAC: begin
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) state_d = S_OUT;
      end
      S_OUT:    if (slot_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o        = '0;
    in_ready_o   = (state_q == S_IDLE);
    cmd_o.latch  = in_ready_o && in_valid_i;
    cmd_o.simple = (state_q == S_DECODE) && !frame_run;
    cmd_o.delta  = (state_q == S_DELTA);
    cmd_o.acc    = (state_q == S_ACC);
    cmd_o.div    = (state_q == S_DIV);
    cmd_o.cap    = (state_q == S_CAP);
    cmd_o.sub    = (state_q == S_SUB);
    cmd_o.fchk   = (state_q == S_FCHK);
    cmd_o.frac   = (state_q == S_FRAC);
    cmd_o.out_ld = (state_q == S_OUT) && slot_free;
    out_valid_d  = cmd_o.out_ld ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_accept_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_DECODE))
    else $error("accepted word did not enter decode");

  a_div_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ACC) |=> ##(ACC_WIDTH) (state_q == S_CAP))
    else $error("division did not run its full length");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> out_valid_q && !$past(cmd_o.out_ld))
    else $error("stalled result was overwritten");

  a_simple_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.simple |=> (state_q == S_OUT))
    else $error("simple event did not go to output");

endmodule
`default_nettype wire

[rtl/fta_dp.sv]
// Datapath: timer state, delta clamp, saturating accumulator, shared shift-subtract divider.
`default_nettype none
module fta_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fta_pkg::dp_cmd_t  cmd_i,
  output fta_pkg::dp_stat_t stat_o,
  input  fta_pkg::cfg_t     cfg_i,
  input  logic [1:0]        in_cmd_i,
  input  fta_pkg::ts_t      in_ts_i,
  output fta_pkg::result_t  res_o
);
  import fta_pkg::*;

  logic [1:0] cmd_q;
  ts_t        ts_q;
  logic       running_q;
  ts_t        last_q;
  acc_t       acc_q;
  cnt16_t     pend_q;
  ts_t        sim_q;
  ts_t        rft_q;
  step_t      rdelta_q;
  cnt16_t     rsteps_q;
  alpha_t     ralpha_q;
  logic       taken_q;

  step_t      delta_q;
  acc_t       dvd_q;
  step_t      rem_q;
  acc_t       prod_q;
  logic       capped_q;
  cnt16_t     steps_q;
  acc_t       rest_q;
  result_t    out_q;

  logic [TS_W:0]      diff;
  ts_t                delta_full;
  step_t              delta_clamp;
  logic [ACC_WIDTH:0] sum;
  acc_t               acc_new;
  logic [STEP_W:0]    sh;
  logic [STEP_W:0]    sh_dif;
  logic               sh_ge;
  step_t              rem_next;
  logic               capped;
  logic [STEP_W+CNT16_W-1:0] prod;
  acc_t               rest;
  logic               rem_ge_step;

  assign diff       = {1'b0, ts_q} - {1'b0, last_q};
  assign delta_full = diff[TS_W] ? '0 : diff[TS_W-1:0];
  assign delta_clamp = ((|delta_full[TS_W-1:STEP_W]) || (delta_full[STEP_W-1:0] > cfg_i.max_delta))
                       ? cfg_i.max_delta : delta_full[STEP_W-1:0];

  assign sum     = {1'b0, acc_q} + (ACC_WIDTH+1)'(delta_q);
  assign acc_new = sum[ACC_WIDTH] ? '1 : sum[ACC_WIDTH-1:0];

  assign sh       = {rem_q, cmd_i.div ? dvd_q[ACC_WIDTH-1] : 1'b0};
  assign sh_dif   = sh - {1'b0, cfg_i.step};
  assign sh_ge    = (sh >= {1'b0, cfg_i.step});
  assign rem_next = sh_ge ? sh_dif[STEP_W-1:0] : sh[STEP_W-1:0];

  assign capped      = dvd_q > ACC_WIDTH'(cfg_i.catchup);
  assign prod        = cfg_i.step * cfg_i.catchup;
  assign rest        = capped_q ? (acc_q - prod_q) : ACC_WIDTH'(rem_q);
  assign rem_ge_step = rest_q >= ACC_WIDTH'(cfg_i.step);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      last_q    <= '0;
      acc_q     <= '0;
      pend_q    <= '0;
      sim_q     <= '0;
      rft_q     <= '0;
      rdelta_q  <= '0;
      rsteps_q  <= '0;
      ralpha_q  <= '0;
    end else begin
      if (cmd_i.simple) begin
        case (cmd_q)
          CMD_FRAME: begin
            running_q <= 1'b1;
            last_q    <= ts_q;
            rft_q     <= ts_q;
            rdelta_q  <= '0;
            rsteps_q  <= '0;
            ralpha_q  <= '0;
          end
          CMD_CONSUME: begin
            if (pend_q != '0) begin
              pend_q <= pend_q - 1'b1;
              sim_q  <= sim_q + TS_W'(cfg_i.step);
            end
          end
          CMD_RESET: begin
            running_q <= 1'b0;
            last_q    <= ts_q;
            acc_q     <= '0;
            pend_q    <= '0;
            sim_q     <= '0;
            rft_q     <= ts_q;
            rdelta_q  <= '0;
            rsteps_q  <= '0;
            ralpha_q  <= '0;
          end
          default: ;
        endcase
      end
      if (cmd_i.delta) begin
        last_q   <= ts_q;
        rft_q    <= ts_q;
        rdelta_q <= delta_clamp;
      end
      if (cmd_i.acc) acc_q <= acc_new;
      if (cmd_i.sub) begin
        acc_q    <= rest;
        pend_q   <= steps_q;
        rsteps_q <= steps_q;
      end
      if (cmd_i.fchk) ralpha_q <= rem_ge_step ? '1 : '0;
      if (cmd_i.frac) ralpha_q <= {ralpha_q[ALPHA_BITS-2:0], sh_ge};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      cmd_q   <= in_cmd_i;
      ts_q    <= in_ts_i;
      taken_q <= 1'b0;
    end
    if (cmd_i.simple) taken_q <= (cmd_q == CMD_CONSUME) && (pend_q != '0);
    if (cmd_i.delta)  delta_q <= delta_clamp;
    if (cmd_i.acc) begin
      dvd_q <= acc_new;
      rem_q <= '0;
    end
    if (cmd_i.div) begin
      rem_q <= rem_next;
      dvd_q <= {dvd_q[ACC_WIDTH-2:0], sh_ge};
    end
    if (cmd_i.cap) begin
      capped_q <= capped;
      steps_q  <= capped ? cfg_i.catchup : dvd_q[CNT16_W-1:0];
      prod_q   <= ACC_WIDTH'(prod);
    end
    if (cmd_i.sub)  rest_q <= rest;
    if (cmd_i.fchk) rem_q  <= rest_q[STEP_W-1:0];
    if (cmd_i.frac) rem_q  <= rem_next;
    if (cmd_i.out_ld) begin
      out_q.frame_time <= rft_q;
      out_q.delta      <= rdelta_q;
      out_q.steps      <= rsteps_q;
      out_q.alpha      <= ALPHA_OUT_W'(ralpha_q);
      out_q.taken      <= taken_q;
      out_q.pending    <= pend_q;
      out_q.sim_time   <= sim_q;
    end
  end

  assign stat_o.cmd         = cmd_q;
  assign stat_o.running     = running_q;
  assign stat_o.rem_ge_step = rem_ge_step;
  assign res_o              = out_q;

endmodule
`default_nettype wire

[rtl/fixed_timestep_accumulator.sv]
// Top level of the fixed-timestep frame accumulator.
//
// Channels: in_i carries one event word (cmd, timestamp_ns); out_o returns
// exactly one result word per event; cfg_i writes step length, maximum frame
// delta and catch-up limit by index, always ready, and is to be used only while
// idle; the block itself does not enforce this. Events are handled one at a
// time. A frame event on a running timer goes through delta clamp, saturating
// add, a 48-step shift-subtract division, catch-up cap with one 32x16 multiply,
// then a 20-step fraction division on the same subtractor; the fraction loop is
// skipped when the catch-up cap leaves a remainder of a full step or more.
// Consume, reset, first frame and the unused code go from decode straight to
// output. The result is loaded into an output register once that register is
// free, and is valid from then on; while it waits, the next event is accepted
// and computed, and only its hand-off waits for the receiver. Reset clears the
// timer state and the result valid flag, and restores register defaults; no
// result is pending after reset.
`default_nettype none
module fixed_timestep_accumulator (
  input  logic      clk_i,
  input  logic      rst_ni,
  fta_in_if.sink    in_i,
  fta_out_if.source out_o,
  fta_cfg_if.sink   cfg_i
);
  import fta_pkg::*;

  cfg_t     cfg;
  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;
  result_t  res;

  fta_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cfg_i.valid),
    .wr_ready_o (cfg_i.ready),
    .wr_index_i (cfg_i.index),
    .wr_data_i  (cfg_i.data),
    .cfg_o      (cfg)
  );

  fta_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (dp_stat),
    .cmd_o       (dp_cmd)
  );

  fta_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (dp_cmd),
    .stat_o   (dp_stat),
    .cfg_i    (cfg),
    .in_cmd_i (in_i.cmd),
    .in_ts_i  (in_i.timestamp_ns),
    .res_o    (res)
  );

  assign out_o.frame_time_ns = res.frame_time;
  assign out_o.frame_dt_ns   = res.delta;
  assign out_o.steps_granted = res.steps;
  assign out_o.alpha_q20     = res.alpha;
  assign out_o.step_taken    = res.taken;
  assign out_o.pending_left  = res.pending;
  assign out_o.sim_clock_ns  = res.sim_time;

endmodule
`default_nettype wire
